[design/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_SERVED   = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic               command;
    logic [15:0]        process_id;
    logic signed [15:0] priority_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        served_id;
    logic signed [15:0] served_priority;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] prio;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } spq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
  } spq_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } spq_stat_t;

endpackage

[design/spq_ifs.sv]
interface spq_in_if import spq_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface spq_out_if import spq_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[design/spq_ctrl.sv]
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  spq_stat_t stat,
  output spq_ctrl_t ctrl
);

  spq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_EXEC: begin
        // wait for the result register to free up
        ctrl.exec = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/spq_datapath.sv]
module spq_datapath import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  spq_ctrl_t ctrl,
  output spq_stat_t stat,
  input  in_item_t  in_item,
  spq_out_if.source out_ch
);

  // latched item
  logic               cmd_r;
  logic [15:0]        id_r;
  logic signed [15:0] pr_r;

  entry_t           cells_r   [CAPACITY];
  entry_t           cells_nxt [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAPACITY-1:0] gt;
  logic             full, empty, do_ins, do_srv;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  entry_t           new_entry;

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign do_ins    = ctrl.exec && (cmd_r == CMD_INSERT) && !full;
  assign do_srv    = ctrl.exec && (cmd_r == CMD_SERVE) && !empty;
  assign new_entry = '{id: id_r, prio: pr_r};

  // gt[i]: cell i sits after the new entry (empty cells count as after)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= count_r) ||
                   ($signed(cells_r[i].prio) > $signed(pr_r));

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i]) begin
          cells_nxt[i] = new_entry;
        end
      end else if (do_srv) begin
        if (i < CAPACITY - 1) begin
          cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_srv) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_item_nxt.served_id       = '0;
    out_item_nxt.served_priority = '0;
    out_item_nxt.occupancy       = OCC_W'(count_nxt);
    if (cmd_r == CMD_INSERT) begin
      out_item_nxt.status = full ? STAT_FULL : STAT_INSERTED;
    end else if (empty) begin
      out_item_nxt.status = STAT_EMPTY;
    end else begin
      out_item_nxt.status          = STAT_SERVED;
      out_item_nxt.served_id       = cells_r[0].id;
      out_item_nxt.served_priority = cells_r[0].prio;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.item   = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_item.command;
      id_r  <= in_item.process_id;
      pr_r  <= in_item.priority_value;
    end
    if (ctrl.exec) begin
      out_item_r <= out_item_nxt;
    end
    cells_r <= cells_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |-> !(out_valid_r && !out_ch.ready))
    else $error("result overwritten before transfer");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.exec))
    else $error("result raised without execution");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the queue");
`endif

endmodule

[design/stable_priority_queue_top.sv]
// channel   dir  handshake      payload
// in_ch     in   valid/ready    command, process_id, priority_value
// out_ch    out  valid/ready    status, served_id, served_priority, occupancy
//
// Each item is first captured into the item register, then used to update the sorted
// cell array (all cells compare against the new priority in parallel).
// A new item is taken while the previous result waits in the output register;
// the update stalls while that register is still full.
// Synchronous active-low reset clears the entry count and the handshake state.
module stable_priority_queue_top import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  spq_ctrl_t ctrl;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  spq_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .stat    (stat),
    .in_item (in_ch.item),
    .out_ch  (out_ch)
  );

endmodule
